### hdl/jsu_pkg.sv
package jsu_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // UTF-8 encoding
    localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF_CONT   = 8'h80;
    localparam logic [5:0]  UTF_MASK   = 6'h3F;
    localparam logic [15:0] CP_1B_LIM  = 16'h0080;
    localparam logic [15:0] CP_2B_LIM  = 16'h0800;

    localparam logic [15:0] CAP_RESET  = 16'd1024;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Digits held after \u, and pending writes of one item
    localparam int HELD_N = 3;
    localparam int PEND_N = 5;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX
    } mode_t;

    // What follows the pending writes of an item
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_FINISH,
        TAIL_ESCAPE,
        TAIL_CHECK
    } tail_t;

    // Classified input item
    typedef struct packed {
        logic       start;
        logic [7:0] data;
        logic       is_end;     // zero byte or quote
        logic       is_zero;
        logic       is_bs;
        logic       is_u;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic [7:0] esc_byte;   // byte after a backslash, mapped
    } jsu_item_t;

    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'd0;
            hex_decode = 5'd0;
            if (b >= 8'h30 && b <= 8'h39) begin
                d = b - 8'h30;
                hex_decode = {1'b1, d[3:0]};
            end else if (b >= 8'h61 && b <= 8'h66) begin
                d = b - 8'h57;
                hex_decode = {1'b1, d[3:0]};
            end else if (b >= 8'h41 && b <= 8'h46) begin
                d = b - 8'h37;
                hex_decode = {1'b1, d[3:0]};
            end
        end
    endfunction

endpackage

### hdl/jsu_front.sv
module jsu_front
    import jsu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_op,
    input  logic [7:0] s_data_byte,
    output jsu_item_t head,
    output logic      head_valid,
    input  logic      pop
);

    jsu_item_t cls;
    logic [4:0] hx;

    jsu_item_t             q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]       count_reg, count_next;
    logic                  push, take;

    // classify
    always_comb begin
        hx          = hex_decode(s_data_byte);
        cls.start   = s_op;
        cls.data    = s_data_byte;
        cls.is_zero = (s_data_byte == CH_NUL);
        cls.is_end  = (s_data_byte == CH_NUL) || (s_data_byte == CH_QUOTE);
        cls.is_bs   = (s_data_byte == CH_BSLASH);
        cls.is_u    = (s_data_byte == CH_U);
        cls.hex_ok  = hx[4];
        cls.hex_val = hx[3:0];
        case (s_data_byte)
            CH_N:    cls.esc_byte = CH_LF;
            CH_R:    cls.esc_byte = CH_CR;
            CH_T:    cls.esc_byte = CH_TAB;
            default: cls.esc_byte = s_data_byte;
        endcase
    end

    assign s_ready    = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_mem_reg[rd_ptr_reg];
    assign push       = s_valid && s_ready;
    assign take       = pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !take) begin
            count_next = count_reg + 1'b1;
        end else if (take && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hdl/jsu_back.sv
module jsu_back
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  jsu_item_t  head,
    input  logic       head_valid,
    output logic       pop,
    input  logic [15:0] cap,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_last,
    output logic       m_found
);

    // decode state
    mode_t       mode_reg, mode_next;
    logic [7:0]  held_reg [HELD_N];
    logic [7:0]  held_next [HELD_N];
    logic [1:0]  hc_reg, hc_next;
    logic [15:0] cv_reg, cv_next;
    logic [15:0] wc_reg, wc_next;
    logic        fin_reg, fin_next;

    // sequencer
    logic        busy_reg, busy_next;
    logic        fin_pend_reg, fin_pend_next;
    logic [7:0]  pend_reg [PEND_N];
    logic [7:0]  pend_next [PEND_N];
    logic [2:0]  pcnt_reg, pcnt_next;
    tail_t       tail_reg, tail_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_has_reg, m_has_next;
    logic        m_last_reg, m_last_next;
    logic        m_found_reg, m_found_next;

    logic        out_free;
    logic [15:0] cv_new;
    logic [15:0] wc_inc;
    logic [16:0] cap17;
    logic        plain;
    logic [2:0]  ins_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign cap17    = {1'b0, cap};
    assign cv_new   = {cv_reg[11:0], head.hex_val};
    assign wc_inc   = wc_reg + 16'd1;
    assign plain    = !head.is_end && !head.is_bs;
    assign ins_idx  = {1'b0, hc_reg} + 3'd1;

    always_comb begin
        mode_next     = mode_reg;
        held_next     = held_reg;
        hc_next       = hc_reg;
        cv_next       = cv_reg;
        wc_next       = wc_reg;
        fin_next      = fin_reg;
        busy_next     = busy_reg;
        fin_pend_next = fin_pend_reg;
        pend_next     = pend_reg;
        pcnt_next     = pcnt_reg;
        tail_next     = tail_reg;
        pop           = 1'b0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_next   = m_byte_reg;
        m_has_next    = m_has_reg;
        m_last_next   = m_last_reg;
        m_found_next  = m_found_reg;

        if (!busy_reg) begin
            if (head_valid) begin
                pop = 1'b1;
                if (head.start) begin
                    mode_next     = MODE_NORMAL;
                    for (int i = 0; i < HELD_N; i++) begin
                        held_next[i] = 8'd0;
                    end
                    hc_next       = 2'd0;
                    cv_next       = 16'd0;
                    wc_next       = 16'd0;
                    fin_next      = 1'b0;
                    busy_next     = 1'b1;
                    fin_pend_next = 1'b0;
                    pcnt_next     = 3'd0;
                    tail_next     = TAIL_CHECK;
                end else if (!fin_reg) begin
                    unique case (mode_reg)
                        MODE_NORMAL: begin
                            if (head.is_end) begin
                                busy_next = 1'b1;
                                pcnt_next = 3'd0;
                                tail_next = TAIL_FINISH;
                            end else if (head.is_bs) begin
                                mode_next = MODE_ESCAPE;
                            end else begin
                                busy_next    = 1'b1;
                                pend_next[0] = head.data;
                                pcnt_next    = 3'd1;
                                tail_next    = TAIL_NONE;
                            end
                        end
                        MODE_ESCAPE: begin
                            mode_next = MODE_NORMAL;
                            if (head.is_zero) begin
                                busy_next = 1'b1;
                                pcnt_next = 3'd0;
                                tail_next = TAIL_FINISH;
                            end else if (head.is_u) begin
                                mode_next = MODE_HEX;
                                hc_next   = 2'd0;
                                cv_next   = 16'd0;
                            end else begin
                                busy_next    = 1'b1;
                                pend_next[0] = head.esc_byte;
                                pcnt_next    = 3'd1;
                                tail_next    = TAIL_NONE;
                            end
                        end
                        MODE_HEX: begin
                            if (head.hex_ok) begin
                                cv_next = cv_new;
                                if (hc_reg != 2'(HELD_N)) begin
                                    held_next[hc_reg] = head.data;
                                    hc_next           = hc_reg + 2'd1;
                                end else begin
                                    mode_next = MODE_NORMAL;
                                    hc_next   = 2'd0;
                                    busy_next = 1'b1;
                                    tail_next = TAIL_NONE;
                                    if (cv_new < CP_1B_LIM) begin
                                        pend_next[0] = cv_new[7:0];
                                        pcnt_next    = 3'd1;
                                    end else if (cv_new < CP_2B_LIM &&
                                                 ({1'b0, wc_reg} + 17'd2) < cap17) begin
                                        pend_next[0] = UTF_LEAD2 | {3'd0, cv_new[10:6]};
                                        pend_next[1] = UTF_CONT | {2'd0, cv_new[5:0] & UTF_MASK};
                                        pcnt_next    = 3'd2;
                                    end else if (({1'b0, wc_reg} + 17'd3) < cap17) begin
                                        pend_next[0] = UTF_LEAD3 | {4'd0, cv_new[15:12]};
                                        pend_next[1] = UTF_CONT | {2'd0, cv_new[11:6] & UTF_MASK};
                                        pend_next[2] = UTF_CONT | {2'd0, cv_new[5:0] & UTF_MASK};
                                        pcnt_next    = 3'd3;
                                    end else begin
                                        // no room: sequence dropped, capacity still checked
                                        pcnt_next = 3'd0;
                                        tail_next = TAIL_CHECK;
                                    end
                                end
                            end else begin
                                // bad digit: '?', held digits, then the byte itself if plain text
                                mode_next    = MODE_NORMAL;
                                hc_next      = 2'd0;
                                busy_next    = 1'b1;
                                pend_next[0] = CH_QMARK;
                                for (int i = 0; i < HELD_N; i++) begin
                                    pend_next[i+1] = held_reg[i];
                                end
                                if (plain) begin
                                    pend_next[ins_idx] = head.data;
                                end
                                pcnt_next = ins_idx + {2'd0, plain};
                                if (head.is_end) begin
                                    tail_next = TAIL_FINISH;
                                end else if (head.is_bs) begin
                                    tail_next = TAIL_ESCAPE;
                                end else begin
                                    tail_next = TAIL_NONE;
                                end
                            end
                        end
                        default: begin
                            mode_next = MODE_NORMAL;
                        end
                    endcase
                end
            end
        end else if (fin_pend_reg) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                m_byte_next   = 8'd0;
                m_has_next    = 1'b0;
                m_last_next   = 1'b1;
                m_found_next  = (wc_reg != 16'd0);
                fin_next      = 1'b1;
                mode_next     = MODE_NORMAL;
                busy_next     = 1'b0;
                fin_pend_next = 1'b0;
            end
        end else if (pcnt_reg != 3'd0) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_byte_next  = pend_reg[0];
                m_has_next   = 1'b1;
                m_last_next  = 1'b0;
                m_found_next = 1'b0;
                wc_next      = wc_inc;
                if (({1'b0, wc_inc} + 17'd1) >= cap17) begin
                    // output full: rest of the item is dropped
                    fin_pend_next = 1'b1;
                end else begin
                    for (int i = 0; i < PEND_N - 1; i++) begin
                        pend_next[i] = pend_reg[i+1];
                    end
                    pcnt_next = pcnt_reg - 3'd1;
                    if (pcnt_reg == 3'd1) begin
                        case (tail_reg)
                            TAIL_FINISH: busy_next = 1'b1;
                            TAIL_ESCAPE: begin
                                mode_next = MODE_ESCAPE;
                                busy_next = 1'b0;
                            end
                            default:     busy_next = 1'b0;
                        endcase
                    end
                end
            end
        end else begin
            case (tail_reg)
                TAIL_FINISH: fin_pend_next = 1'b1;
                TAIL_CHECK: begin
                    if (({1'b0, wc_reg} + 17'd1) >= cap17) begin
                        fin_pend_next = 1'b1;
                    end else begin
                        busy_next = 1'b0;
                    end
                end
                TAIL_ESCAPE: begin
                    mode_next = MODE_ESCAPE;
                    busy_next = 1'b0;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_NORMAL;
            for (int i = 0; i < HELD_N; i++) begin
                held_reg[i] <= 8'd0;
            end
            hc_reg       <= 2'd0;
            cv_reg       <= 16'd0;
            wc_reg       <= 16'd0;
            fin_reg      <= 1'b1;
            busy_reg     <= 1'b0;
            fin_pend_reg <= 1'b0;
            pcnt_reg     <= 3'd0;
            tail_reg     <= TAIL_NONE;
            m_valid_reg  <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            held_reg     <= held_next;
            hc_reg       <= hc_next;
            cv_reg       <= cv_next;
            wc_reg       <= wc_next;
            fin_reg      <= fin_next;
            busy_reg     <= busy_next;
            fin_pend_reg <= fin_pend_next;
            pcnt_reg     <= pcnt_next;
            tail_reg     <= tail_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg    <= pend_next;
        m_byte_reg  <= m_byte_next;
        m_has_reg   <= m_has_next;
        m_last_reg  <= m_last_next;
        m_found_reg <= m_found_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_has_byte = m_has_reg;
    assign m_last     = m_last_reg;
    assign m_found    = m_found_reg;

endmodule

### hdl/json_string_unescape.sv
// JSON string body unescaper with UTF-8 output.
// Input channel (s_): one item per byte of the string body. s_op = 1 starts a
// new string and clears the decoder; s_op = 0 carries a text byte.
// Result channel (m_): decoded bytes (m_has_byte = 1) and one closing item
// (m_last = 1, m_found = something was written) per string.
// Config channel (cfg_): writes out_capacity; write only while the block is idle.
// The front classifies each byte and parks it in a two-item queue; the back
// sequencer decodes it and puts out one result item per cycle while m_ready
// allows, via an output register; a stall on one side holds up the other
// only once the queue is full or empty. The back sequencer loads one item,
// then emits its results one per cycle; it takes no new item from the queue
// until it is through with the last. A backslash or a non-final hex digit
// gives no result of its own.
// Reset: capacity returns to 1024 and the block sits finished, ignoring text
// bytes until a start item. A stalled m_ready fills the output register, then
// the queue, then drops s_ready.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_has_byte,
    output logic        m_last,
    output logic        m_found,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0] cap_reg;
    jsu_item_t   head;
    logic        head_valid;
    logic        pop;

    // capacity register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    jsu_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_byte (s_data_byte),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop)
    );

    jsu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .cap         (cap_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_byte  (m_has_byte),
        .m_last      (m_last),
        .m_found     (m_found)
    );

    // back never pulls from an empty queue
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

    // closing item carries no byte
    a_last_nobyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_has_byte && (m_out_byte == 8'd0))
        else $error("closing item carries a byte");

    // found only on the closing item
    a_found_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_last)
        else $error("found outside closing item");

    // a stalled result stays valid until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped under stall");

endmodule
